/* design/adaptive_quadratic_interp_1d_assert.svh */
// Assertion macros shared by the interpolator RTL.
// Every property is clocked on clk_i and disabled while rst_ni is low.
`ifndef ADAPTIVE_QUADRATIC_INTERP_1D_ASSERT_SVH
`define ADAPTIVE_QUADRATIC_INTERP_1D_ASSERT_SVH

// Overlapping implication: the consequent is checked from the same edge.
`define AQI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Non-overlapping implication: the consequent is checked at the next edge.
`define AQI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/aqi1d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aqi1d_pkg;

  // Register map: register index is paddr[2].
  typedef enum logic {
    REG_SCHEME    = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_e;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SchemeW = 2;
  localparam int unsigned ThreshW = 31;
  localparam int unsigned AddrW   = 3;

  localparam logic [SchemeW-1:0] SCHEME_ONE = 2'd1;
  localparam logic [SchemeW-1:0] SCHEME_TWO = 2'd2;

  localparam logic [SchemeW-1:0] SCHEME_RESET    = SCHEME_ONE;
  localparam logic [ThreshW-1:0] THRESHOLD_RESET = 31'd168;

  localparam logic signed [DataW-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] VALUE_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

/* design/adaptive_quadratic_interp_1d.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_quadratic_interp_1d_assert.svh"

// One-dimensional adaptive quadratic interpolator.
//
// A query is four grid samples (sample_left_i, sample_base_i, sample_right_i,
// sample_far_i, signed Q8.24) and a fraction frac_i (Q0.16). A transfer is
// accepted at a rising edge where start is high and busy is low. busy is
// always low, so a new query can be issued in every cycle.
//
// The result value_o (signed Q8.24, rounded and saturated) is shown for one
// cycle with result_valid_o high, after the five register stages of the
// datapath (differences, branch select and linear product, correction
// partial products, product merge and shift, final sum and saturation),
// and is taken at the edge that ends that cycle. Throughput is one result
// per cycle.
//
// The receiver has no way to stall the block, so nothing is held back.
// Reset clears the stage valid bits and loads the registers with scheme 1
// and a threshold of 168. The user must write configuration over the APB port
// only while no query is in flight; the block itself does not enforce this.
module adaptive_quadratic_interp_1d (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Query channel.
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [aqi1d_pkg::DataW-1:0]    sample_left_i,
  input  wire logic signed [aqi1d_pkg::DataW-1:0]    sample_base_i,
  input  wire logic signed [aqi1d_pkg::DataW-1:0]    sample_right_i,
  input  wire logic signed [aqi1d_pkg::DataW-1:0]    sample_far_i,
  input  wire logic        [aqi1d_pkg::FracW-1:0]    frac_i,
  // Result channel.
  output logic                                       result_valid_o,
  output logic signed      [aqi1d_pkg::DataW-1:0]    value_o,
  // Configuration port.
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic        [aqi1d_pkg::AddrW-1:0]    paddr,
  input  wire logic        [31:0]                    pwdata,
  output logic             [31:0]                    prdata,
  output logic                                       pready
);
  import aqi1d_pkg::*;

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [SchemeW-1:0] scheme_q;
  logic [ThreshW-1:0] thresh_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SCHEME_RESET;
      thresh_q <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SCHEME:    scheme_q <= pwdata[SchemeW-1:0];
        REG_THRESHOLD: thresh_q <= pwdata[ThreshW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_SCHEME:    prdata = {30'd0, scheme_q};
      REG_THRESHOLD: prdata = {1'b0, thresh_q};
      default:       prdata = '0;
    endcase
  end

  // The datapath never stalls.
  assign busy = 1'b0;

  // ------------------------------------------------------------------
  // Stage 1: magnitude tests, all candidate correction sums, the product q.
  // The correction is carried as f = -e so that P*e = q*f with
  // q = frac*(65536-frac) >= 0.
  // ------------------------------------------------------------------
  logic                     accept;
  logic signed [34:0]       l_x, b_x, r_x, f_x;
  logic        [31:0]       abs_b, abs_r;
  logic        [32:0]       q_full;

  logic                     v1_q;
  logic                     ok1_q, two1_q, bigb1_q, bigr1_q;
  logic        [30:0]       q1_q;
  logic signed [32:0]       rb1_q;
  logic signed [31:0]       b1_q;
  logic        [FracW-1:0]  fr1_q;
  logic signed [34:0]       d1_1_q, d2_1_q, f1a_1_q, f1b_1_q, f2a_1_q, f2b_1_q;

  assign accept = start && !busy;
  assign l_x    = 35'(sample_left_i);
  assign b_x    = 35'(sample_base_i);
  assign r_x    = 35'(sample_right_i);
  assign f_x    = 35'(sample_far_i);
  assign abs_b  = sample_base_i[31] ? ($unsigned(~sample_base_i) + 32'd1)
                                    : $unsigned(sample_base_i);
  assign abs_r  = sample_right_i[31] ? ($unsigned(~sample_right_i) + 32'd1)
                                     : $unsigned(sample_right_i);
  // frac*(65536-frac) peaks at 2^30, so 31 bits hold it.
  assign q_full = 33'(frac_i) * 33'(17'h1_0000 - {1'b0, frac_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q   <= (scheme_q == SCHEME_ONE) || (scheme_q == SCHEME_TWO);
    two1_q  <= (scheme_q == SCHEME_TWO);
    bigb1_q <= abs_b > {1'b0, thresh_q};
    bigr1_q <= abs_r > {1'b0, thresh_q};
    q1_q    <= q_full[30:0];
    rb1_q   <= 33'(sample_right_i) - 33'(sample_base_i);
    b1_q    <= sample_base_i;
    fr1_q   <= frac_i;
    d1_1_q  <= f_x + b_x - (r_x <<< 1);
    d2_1_q  <= r_x + l_x - (b_x <<< 1);
    f1a_1_q <= b_x - l_x + r_x - f_x;
    f1b_1_q <= b_x - l_x + r_x + f_x;
    f2a_1_q <= (r_x <<< 1) - b_x - f_x;
    f2b_1_q <= (b_x <<< 1) - l_x - r_x;
  end

  // ------------------------------------------------------------------
  // Stage 2: branch selection and the linear-term product (R-B)*frac.
  // ------------------------------------------------------------------
  logic        [34:0] ad1, ad2;
  logic signed [34:0] f_sel;

  logic               v2_q, ok2_q, two2_q;
  logic        [30:0] q2_q;
  logic signed [34:0] f2_q;
  logic signed [31:0] b2_q;
  logic signed [49:0] lmul2_q;

  assign ad1 = d1_1_q[34] ? $unsigned(-d1_1_q) : $unsigned(d1_1_q);
  assign ad2 = d2_1_q[34] ? $unsigned(-d2_1_q) : $unsigned(d2_1_q);

  always_comb begin
    f_sel = '0;
    if (!two1_q) begin
      if (bigb1_q && bigr1_q) begin
        f_sel = f1a_1_q;
      end else if (bigb1_q || bigr1_q) begin
        f_sel = f1b_1_q;
      end
    end else if (bigb1_q || bigr1_q) begin
      // Ties go to the second branch.
      f_sel = (ad1 < ad2) ? f2a_1_q : f2b_1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok2_q   <= ok1_q;
    two2_q  <= two1_q;
    q2_q    <= q1_q;
    f2_q    <= f_sel;
    b2_q    <= b1_q;
    lmul2_q <= 50'(rb1_q) * 50'($signed({1'b0, fr1_q}));
  end

  // ------------------------------------------------------------------
  // Stage 3: q*f as two partial products, and lin = B*2^16 + (R-B)*frac.
  // ------------------------------------------------------------------
  logic               v3_q, ok3_q, two3_q;
  logic        [48:0] pplo3_q;
  logic signed [48:0] pphi3_q;
  logic signed [51:0] lin3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok3_q   <= ok2_q;
    two3_q  <= two2_q;
    pplo3_q <= 49'(q2_q) * 49'(f2_q[17:0]);
    pphi3_q <= 49'($signed({1'b0, q2_q})) * 49'($signed(f2_q[34:18]));
    lin3_q  <= 52'(lmul2_q) + (52'(b2_q) <<< 16);
  end

  // ------------------------------------------------------------------
  // Stage 4: merge the partial products and floor-shift by 17 or 18.
  // ------------------------------------------------------------------
  logic signed [66:0] prod;
  logic signed [66:0] prod_sh;

  logic               v4_q, ok4_q;
  logic signed [51:0] lin4_q;
  logic signed [51:0] corr4_q;

  assign prod    = (67'(pphi3_q) <<< 18) + 67'($signed({1'b0, pplo3_q}));
  assign prod_sh = two3_q ? (prod >>> 17) : (prod >>> 18);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok4_q   <= ok3_q;
    lin4_q  <= lin3_q;
    corr4_q <= prod_sh[51:0];
  end

  // ------------------------------------------------------------------
  // Stage 5: round to Q8.24 (ties up), saturate or give zero for an unused scheme, drive the result ports.
  // ------------------------------------------------------------------
  logic signed [51:0]      sum_n;
  logic signed [35:0]      v_full;
  logic signed [DataW-1:0] value_d;
  logic signed [DataW-1:0] value_q;
  logic                    rvld_q;

  assign sum_n  = lin4_q + corr4_q + 52'sd32768;
  assign v_full = sum_n[51:16];

  always_comb begin
    if (!ok4_q) begin
      value_d = '0;
    end else if ((v_full[35:31] == 5'b00000) || (v_full[35:31] == 5'b11111)) begin
      value_d = v_full[31:0];
    end else if (v_full[35]) begin
      value_d = VALUE_MIN;
    end else begin
      value_d = VALUE_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign result_valid_o = rvld_q;
  assign value_o        = value_q;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `AQI_ASSERT_IMP(a_latency, accept, ##5 result_valid_o, "query did not yield a result")
  `AQI_ASSERT_NXT(a_bubble, !v4_q, !result_valid_o, "result strobe without a query")
  `AQI_ASSERT_NXT(a_bad_scheme, v4_q && !ok4_q, value_o == '0, "unused scheme gave nonzero")
  `AQI_ASSERT_NXT(a_small_zero, v1_q && !bigb1_q && !bigr1_q, f2_q == '0,
                  "correction applied to small samples")

endmodule

`default_nettype wire
